// ===== src/time_window_running_mean_macros.svh =====
// Assertion macros for the RTL of the running mean block.
// Each macro checks an implication at every rising clock edge outside reset.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef TIME_WINDOW_RUNNING_MEAN_MACROS_SVH
`define TIME_WINDOW_RUNNING_MEAN_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define TWRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TWRM_ASSERT_NOW(lbl, ante, cons, msg)
`define TWRM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/twrm_pkg.sv =====
`timescale 1ns / 1ps

package twrm_pkg;

    // Field widths fixed by the interface.
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 40;
    localparam int HC_W   = 9;
    localparam int WIN_W  = 16;
    localparam int FRAC_W = 8;
    localparam int DVD_W  = SUM_W + FRAC_W;

    // Default sizing of the sample queue and of the tick counter.
    localparam int FIFO_DEPTH_DEF = 256;
    localparam int STAMP_BITS_DEF = 32;

    // Window length after reset.
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);

    // Item kinds.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_PUSH = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MEAN,
        ST_DIV,
        ST_FIN
    } state_t;

    // Status of the divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/twrm_store.sv =====
`timescale 1ns / 1ps

module twrm_store #(
    parameter int DEPTH  = twrm_pkg::FIFO_DEPTH_DEF,
    parameter int STAMP_W = twrm_pkg::STAMP_BITS_DEF,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [twrm_pkg::VAL_W-1:0] wr_value,
    input  logic [STAMP_W-1:0]         wr_stamp,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [twrm_pkg::VAL_W-1:0] rd_value,
    output logic [STAMP_W-1:0]         rd_stamp
);

    logic [twrm_pkg::VAL_W-1:0] value_mem [DEPTH];
    logic [STAMP_W-1:0]         stamp_mem [DEPTH];

    // One write port for the pushed sample and its arrival tick.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_value;
            stamp_mem[wr_addr] <= wr_stamp;
        end
    end

    // One registered read port for the oldest entry.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_value <= value_mem[rd_addr];
            rd_stamp <= stamp_mem[rd_addr];
        end
    end

endmodule

// ===== src/twrm_div.sv =====
`timescale 1ns / 1ps

module twrm_div #(
    parameter int CNT_W = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [twrm_pkg::DVD_W-1:0] dividend,
    input  logic [CNT_W-1:0]           divisor,
    output logic [twrm_pkg::DVD_W-1:0] quotient,
    output twrm_pkg::div_stat_t        stat
);

    localparam int DW     = twrm_pkg::DVD_W;
    localparam int STEP_W = $clog2(DW);

    logic [DW-1:0]     quo_reg;
    logic [DW-1:0]     quo_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;

    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    dsr_ext;
    logic [CNT_W:0]    rem_diff;
    logic              fits;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DW-1]};
        dsr_ext   = {1'b0, dsr_reg};
        rem_diff  = rem_shift - dsr_ext;
        fits      = (rem_shift >= dsr_ext);
    end

    // Step control: one quotient bit per cycle, most significant first.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(DW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working data needs no reset.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== src/time_window_running_mean.sv =====
// Sequence: a push is stored (or dropped when the queue is full), then the sum is divided by
// the held count and the result beat is loaded. A tick reads and checks the head entry, retiring
// it while expired, until an unexpired head or an empty queue ends the loop; it then divides the
// same way, but with nothing held the divider is skipped. Throughput: one item at a time, taken
// the cycle after its beat is loaded, so an item waits for the previous beat to be taken.
// Reset (asynchronous, active low) empties the queue, zeroes sum and tick count, sets window 10.
`timescale 1ns / 1ps

`include "time_window_running_mean_macros.svh"

module time_window_running_mean #(
    parameter int FIFO_DEPTH = twrm_pkg::FIFO_DEPTH_DEF,
    parameter int STAMP_BITS = twrm_pkg::STAMP_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic signed [twrm_pkg::VAL_W-1:0] value,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [twrm_pkg::SUM_W-1:0] mean_fixed,
    output logic [twrm_pkg::HC_W-1:0]         held_count,
    output logic signed [twrm_pkg::SUM_W-1:0] window_sum,
    output logic                              empty_res,
    output logic                              dropped,
    // Window length register
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [twrm_pkg::WIN_W-1:0]        cfg_data
);

    localparam int AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SW    = twrm_pkg::SUM_W;
    localparam int VW    = twrm_pkg::VAL_W;
    localparam int DW    = twrm_pkg::DVD_W;

    twrm_pkg::state_t state_reg;
    twrm_pkg::state_t state_next;

    logic [STAMP_BITS-1:0]  time_reg;
    logic [STAMP_BITS-1:0]  time_next;
    logic [AW-1:0]          head_reg;
    logic [AW-1:0]          head_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [SW-1:0]          sum_reg;
    logic [SW-1:0]          sum_next;
    logic [twrm_pkg::WIN_W-1:0] window_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic                   drop_reg;
    logic                   drop_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [SW-1:0]          mean_reg;
    logic [SW-1:0]          mean_next;

    logic [SW-1:0]          out_mean_reg;
    logic [CNT_W-1:0]       out_count_reg;
    logic [SW-1:0]          out_sum_reg;
    logic                   out_empty_reg;
    logic                   out_drop_reg;
    logic                   out_load;

    logic                   in_accept;
    logic                   wr_en;
    logic [AW:0]            slot_sum;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic [VW-1:0]          rd_value;
    logic [STAMP_BITS-1:0]  rd_stamp;
    logic [STAMP_BITS-1:0]  age;
    logic                   expired;

    logic                   div_start;
    logic [DW-1:0]          scaled;
    logic [DW-1:0]          dividend;
    logic [DW-1:0]          quotient;
    twrm_pkg::div_stat_t    div_stat;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != twrm_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Tail slot of the circular queue.
    always_comb
    begin
        slot_sum = {1'b0, head_reg} + (AW + 1)'(count_reg);
        if (slot_sum >= (AW + 1)'(FIFO_DEPTH))
        begin
            slot_sum = slot_sum - (AW + 1)'(FIFO_DEPTH);
        end
        wr_addr = slot_sum[AW-1:0];
    end

    // Age of the oldest entry against the window length.
    always_comb
    begin
        age     = time_reg - rd_stamp;
        expired = (age > {{(STAMP_BITS - twrm_pkg::WIN_W){1'b0}}, window_reg});
    end

    // Magnitude of the sum scaled by 256 for the divider.
    always_comb
    begin
        scaled   = {sum_reg, {twrm_pkg::FRAC_W{1'b0}}};
        dividend = sum_reg[SW-1] ? (~scaled + 1'b1) : scaled;
    end

    // Sequencer: retire loop, mean division and result hand-off.
    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        drop_next      = drop_reg;
        neg_next       = neg_reg;
        mean_next      = mean_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            twrm_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    drop_next = 1'b0;
                    if (kind == twrm_pkg::KIND_TICK)
                    begin
                        time_next  = time_reg + 1'b1;
                        state_next = (count_reg != '0) ? twrm_pkg::ST_READ
                                                       : twrm_pkg::ST_MEAN;
                    end
                    else if (count_reg == CNT_W'(FIFO_DEPTH))
                    begin
                        drop_next  = 1'b1;
                        state_next = twrm_pkg::ST_MEAN;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + {{(SW - VW){value[VW-1]}}, value};
                        state_next = twrm_pkg::ST_MEAN;
                    end
                end
            end

            twrm_pkg::ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = twrm_pkg::ST_CHECK;
            end

            twrm_pkg::ST_CHECK:
            begin
                if (expired)
                begin
                    sum_next   = sum_reg - {{(SW - VW){rd_value[VW-1]}}, rd_value};
                    head_next  = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = (count_reg != CNT_W'(1)) ? twrm_pkg::ST_READ
                                                          : twrm_pkg::ST_MEAN;
                end
                else
                begin
                    state_next = twrm_pkg::ST_MEAN;
                end
            end

            twrm_pkg::ST_MEAN:
            begin
                if (count_reg == '0)
                begin
                    mean_next  = '0;
                    state_next = twrm_pkg::ST_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    neg_next   = sum_reg[SW-1];
                    state_next = twrm_pkg::ST_DIV;
                end
            end

            twrm_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    mean_next  = neg_reg ? (~quotient[SW-1:0] + 1'b1) : quotient[SW-1:0];
                    state_next = twrm_pkg::ST_FIN;
                end
            end

            twrm_pkg::ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = twrm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = twrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twrm_pkg::ST_IDLE;
            time_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Window length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= twrm_pkg::WIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_reg <= cfg_data;
        end
    end

    // Per-item working values.
    always_ff @(posedge clk)
    begin
        drop_reg <= drop_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
    end

    // Result register, loaded once the previous beat has been taken.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mean_reg  <= mean_reg;
            out_count_reg <= count_reg;
            out_sum_reg   <= sum_reg;
            out_empty_reg <= (count_reg == '0);
            out_drop_reg  <= drop_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mean_fixed = out_mean_reg;
    assign held_count = (twrm_pkg::HC_W)'(out_count_reg);
    assign window_sum = out_sum_reg;
    assign empty_res  = out_empty_reg;
    assign dropped    = out_drop_reg;

    // Sample and arrival-tick memory.
    twrm_store #(
        .DEPTH   (FIFO_DEPTH),
        .STAMP_W (STAMP_BITS),
        .AW      (AW)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_value (value),
        .wr_stamp (time_reg),
        .rd_en    (rd_en),
        .rd_addr  (head_reg),
        .rd_value (rd_value),
        .rd_stamp (rd_stamp)
    );

    // Restoring divider for the mean.
    twrm_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // The queue never holds more entries than it has slots.
    `TWRM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH),
                     "entry count above depth")

    // An entry is only examined for expiry while the queue holds something.
    `TWRM_ASSERT_NOW(a_check_nonempty, state_reg == twrm_pkg::ST_CHECK, count_reg != '0,
                     "expiry check on empty queue")

    // While waiting on the divider, the divider is either working or finishing.
    `TWRM_ASSERT_NOW(a_div_alive, state_reg == twrm_pkg::ST_DIV,
                     div_stat.busy || div_stat.done, "divider idle while awaited")

    // A push into a queue with room is never reported as dropped.
    `TWRM_ASSERT_NEXT(a_no_false_drop,
                      in_accept && kind == twrm_pkg::KIND_PUSH && count_reg != CNT_W'(FIFO_DEPTH),
                      !drop_reg, "push dropped with room left")

    // An empty result reports a zero mean and a zero sum.
    `TWRM_ASSERT_NOW(a_empty_zero, out_valid_reg && out_empty_reg,
                     out_mean_reg == '0 && out_sum_reg == '0,
                     "empty result with nonzero mean or sum")

endmodule
